// File: rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

	// The base field has a fixed width.
	localparam int BASE_WIDTH = 63;

	// The modulus comes out of reset as this prime.
	localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

endpackage

// File: rtl/mexp_if.sv
// ----------------------------------------------------------------------------
// mexp_req_if / mexp_rsp_if
// Valid/ready channels that carry request and result items.
// ----------------------------------------------------------------------------
interface mexp_req_if import mexp_pkg::*; #(
	parameter int EXP_WIDTH = 63
);
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [BASE_WIDTH-1:0] base;
	logic [EXP_WIDTH-1:0]  exponent;

	modport source (output valid, action, base, exponent, input ready);
	modport sink   (input valid, action, base, exponent, output ready);
endinterface

interface mexp_rsp_if #(
	parameter int MOD_WIDTH = 31
);
	logic                 valid;
	logic                 ready;
	logic [MOD_WIDTH-1:0] result;

	modport source (output valid, result, input ready);
	modport sink   (input valid, result, output ready);
endinterface

// File: rtl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] product
);

	localparam int CW = $clog2(W);

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0] dbl;
	logic [W:0] dbl_red;
	logic [W:0] sum;
	logic [W:0] sum_red;

	// Horner step: acc = 2*acc (+ a when the current bit of b is set), kept below m.
	// Operands are below m, so each partial value stays below 2m and one subtract suffices.
	always_comb begin
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
		sum     = dbl_red + (b_q[W-1] ? {1'b0, a_q} : '0);
		sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= sum_red[W-1:0];
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// File: rtl/modular_exponentiation.sv
// Sequence: reduce the base, then for each exponent bit a step, a multiply when the
// bit is one and a squaring on the multiplier, then post the result.
// One item at a time: the bit-serial modular multiplier sets the rate.
// A new item is taken while the previous result still waits in the output register.
// Reset: modulus returns to 1000000007, the sequencer idles, no result is pending.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus, or base^(modulus-2) mod modulus for the
// inverse action, by right-to-left binary square-and-multiply.
// ----------------------------------------------------------------------------
module modular_exponentiation import mexp_pkg::*; #(
	parameter int MOD_WIDTH = 31,
	parameter int EXP_WIDTH = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [MOD_WIDTH-1:0] cfg_wr_data,
	mexp_req_if.sink             req,
	mexp_rsp_if.source           rsp
);

	localparam int XW  = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
	localparam int BCW = $clog2(BASE_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [MOD_WIDTH-1:0]  modulus_q;
	logic [BASE_WIDTH-1:0] base_q;
	logic [BCW-1:0]        bcnt_q;
	logic [XW-1:0]         exp_q;
	logic [MOD_WIDTH-1:0]  pow_q;
	logic [MOD_WIDTH-1:0]  acc_q;
	logic                  mm_start_q;
	logic                  rsp_valid_q;
	logic [MOD_WIDTH-1:0]  result_q;

	logic [MOD_WIDTH-1:0]  mm_a;
	logic                  mm_done;
	logic [MOD_WIDTH-1:0]  mm_product;
	logic [MOD_WIDTH:0]    red_shift;
	logic [MOD_WIDTH:0]    red_next;

	// Base reduction: shift the base in MSB first, keeping the remainder below modulus.
	always_comb begin
		red_shift = {pow_q, base_q[BASE_WIDTH-1]};
		red_next  = (red_shift >= {1'b0, modulus_q}) ? red_shift - {1'b0, modulus_q}
			: red_shift;
	end

	assign mm_a = (state_q == ST_SQR) ? pow_q : acc_q;

	mexp_mulmod #(
		.W(MOD_WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start_q),
		.a      (mm_a),
		.b      (pow_q),
		.m      (modulus_q),
		.done   (mm_done),
		.product(mm_product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_WIDTH'(MODULUS_RESET);
		end else if (cfg_wr_en) begin
			modulus_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mm_start_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			bcnt_q      <= '0;
		end else begin
			// A multiply or square starts after a step with bits left, and a square follows a multiply.
			mm_start_q <= ((state_q == ST_STEP) && (exp_q != '0))
				|| ((state_q == ST_MUL) && mm_done);
			if ((state_q == ST_DONE) && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						bcnt_q <= '0;
						if (modulus_q < MOD_WIDTH'(2)) begin
							// No reduction is possible; the result is zero.
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					bcnt_q <= bcnt_q + 1'b1;
					if (bcnt_q == BCW'(BASE_WIDTH - 1)) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (exp_q == '0) begin
						state_q <= ST_DONE;
					end else if (exp_q[0]) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_SQR;
					end
				end
				ST_MUL: begin
					if (mm_done) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (mm_done) begin
						state_q <= ST_STEP;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				base_q <= req.base;
				pow_q  <= '0;
				acc_q  <= '0;
				exp_q  <= req.action ? XW'(modulus_q - MOD_WIDTH'(2)) : XW'(req.exponent);
			end
			ST_REDUCE: begin
				pow_q  <= red_next[MOD_WIDTH-1:0];
				base_q <= {base_q[BASE_WIDTH-2:0], 1'b0};
				acc_q  <= MOD_WIDTH'(1);
			end
			ST_MUL: begin
				if (mm_done) begin
					acc_q <= mm_product;
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					pow_q <= mm_product;
					exp_q <= exp_q >> 1;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					result_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready  = (state_q == ST_IDLE);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.result = result_q;

endmodule
